[hw/rtl/gncc_pkg.sv]
package gncc_pkg;

	localparam int GRID_WIDTH_DEF    = 64;
	localparam int GRID_HEIGHT_DEF   = 64;
	localparam int MAX_TERMINALS_DEF = 16;
	localparam int CMDQ_DEPTH        = 4;

	localparam logic [1:0] CELL_EMPTY = 2'd0;
	localparam logic [1:0] CELL_VIA   = 2'd2;

	localparam logic OP_CELL = 1'b0;

	typedef struct packed {
		logic       operation;
		logic [5:0] col;
		logic [5:0] row;
		logic       metal_layer;
		logic [1:0] cell_code;
		logic       last_terminal;
	} in_item_t;

	typedef struct packed {
		logic net_passed;
		logic cycle_seen;
		logic all_reached;
		logic terminals_dropped;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_CELL,
		KIND_TERM,
		KIND_LAST
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       in_grid;
		logic [5:0] col;
		logic [5:0] row;
		logic       layer;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic       in_grid;
		logic [5:0] col;
		logic [5:0] row;
		logic       layer;
	} term_t;

	typedef enum logic [2:0] {
		MV_NONE  = 3'd0,
		MV_START = 3'd1,
		MV_LEFT  = 3'd2,
		MV_RIGHT = 3'd3,
		MV_UP    = 3'd4,
		MV_DOWN  = 3'd5,
		MV_VIA   = 3'd6
	} move_t;

	typedef enum logic [3:0] {
		ST_RCLR,
		ST_IDLE,
		ST_START,
		ST_POP,
		ST_POP_W,
		ST_CUR_W,
		ST_MOVE,
		ST_NB_W,
		ST_CHK,
		ST_CHK_W,
		ST_RESULT,
		ST_CLR
	} state_t;

	function automatic move_t inverse_move(input move_t m);
		move_t r;
		unique case (m)
			MV_LEFT:  r = MV_RIGHT;
			MV_RIGHT: r = MV_LEFT;
			MV_UP:    r = MV_DOWN;
			MV_DOWN:  r = MV_UP;
			MV_VIA:   r = MV_VIA;
			default:  r = MV_NONE;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/gncc_front.sv]
module gncc_front import gncc_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  in_item_t item,
	output logic     cmd_valid,
	input  logic     cmd_pop,
	output cmd_t     cmd
);

	localparam int PW = $clog2(CMDQ_DEPTH);

	cmd_t          slot_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	cmd_t          cmd_in;
	logic          push;
	logic          pop;

	always_comb begin
		cmd_in.in_grid = (32'(item.col) < GRID_WIDTH) && (32'(item.row) < GRID_HEIGHT);
		cmd_in.col     = item.col;
		cmd_in.row     = item.row;
		cmd_in.layer   = item.metal_layer;
		cmd_in.code    = item.cell_code;
		if (item.operation == OP_CELL) begin
			cmd_in.kind = KIND_CELL;
		end else if (item.last_terminal) begin
			cmd_in.kind = KIND_LAST;
		end else begin
			cmd_in.kind = KIND_TERM;
		end
	end

	assign item_stall = (count_q == (PW+1)'(CMDQ_DEPTH));
	assign push       = item_valid && !item_stall;
	assign cmd_valid  = (count_q != '0);
	assign pop        = cmd_pop && cmd_valid;
	assign cmd        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/gncc_back.sv]
module gncc_back import gncc_pkg::*; #(
	parameter int GRID_WIDTH    = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT   = GRID_HEIGHT_DEF,
	parameter int MAX_TERMINALS = MAX_TERMINALS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	input  cmd_t      cmd,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	localparam int XW  = $clog2(GRID_WIDTH);
	localparam int YW  = $clog2(GRID_HEIGHT);
	localparam int CW  = XW + YW;
	localparam int AW  = CW + 1;
	localparam int TIW = $clog2(MAX_TERMINALS);
	localparam int TCW = $clog2(MAX_TERMINALS + 1);

	logic [1:0]    cell_mem [2**CW];
	logic [2:0]    par_mem  [2**AW];
	logic [AW-1:0] que_mem  [2**AW];
	term_t         term_q   [MAX_TERMINALS];

	state_t        state_q, state_d;
	logic [1:0]    cell_rd_q;
	logic [2:0]    par_rd_q;
	logic [AW-1:0] que_rd_q;
	logic [AW:0]   head_q, tail_q, clr_q;
	logic          pend_q;
	logic [AW-1:0] cur_q, nb_q;
	logic [1:0]    cell_cur_q;
	move_t         par_cur_q;
	move_t         move_q;
	logic [TCW-1:0] tcount_q, chk_q;
	logic          ovf_q, cyc_q, reached_q;
	out_item_t     result_q;
	logic          result_valid_q;

	logic          cell_we, par_we, que_we;
	logic [CW-1:0] cell_wa, cell_ra;
	logic [AW-1:0] par_wa, par_ra, que_wa, que_ra;
	logic [2:0]    par_wd;
	logic [AW-1:0] que_wd;

	logic          cur_l, nb_ok, nb_pass, last_move, out_free;
	logic [YW-1:0] cur_y;
	logic [XW-1:0] cur_x;
	logic [AW-1:0] nb, start_node, chk_node;
	term_t         chk_term;

	assign cur_l     = cur_q[AW-1];
	assign cur_y     = cur_q[AW-2:XW];
	assign cur_x     = cur_q[XW-1:0];
	assign last_move = (move_q == MV_VIA);
	assign out_free  = !result_valid_q || !result_stall;
	assign chk_term  = term_q[chk_q[TIW-1:0]];
	assign start_node = {term_q[0].layer, YW'(term_q[0].row), XW'(term_q[0].col)};
	assign chk_node   = {chk_term.layer, YW'(chk_term.row), XW'(chk_term.col)};
	assign nb_pass    = (move_q == MV_VIA) || (cell_rd_q != CELL_EMPTY);

	// Neighbor of the current node for the move under test.
	always_comb begin
		nb_ok = 1'b0;
		nb    = cur_q;
		unique case (move_q)
			MV_LEFT: begin
				nb_ok = !cur_l && (cur_x != '0);
				nb    = {cur_l, cur_y, cur_x - 1'b1};
			end
			MV_RIGHT: begin
				nb_ok = !cur_l && ((32'(cur_x) + 1) < GRID_WIDTH);
				nb    = {cur_l, cur_y, cur_x + 1'b1};
			end
			MV_UP: begin
				nb_ok = cur_l && (cur_y != '0);
				nb    = {cur_l, cur_y - 1'b1, cur_x};
			end
			MV_DOWN: begin
				nb_ok = cur_l && ((32'(cur_y) + 1) < GRID_HEIGHT);
				nb    = {cur_l, cur_y + 1'b1, cur_x};
			end
			MV_VIA: begin
				nb_ok = (cell_cur_q == CELL_VIA);
				nb    = {~cur_l, cur_y, cur_x};
			end
			default: begin
				nb_ok = 1'b0;
				nb    = cur_q;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		cell_we = 1'b0;
		cell_wa = {YW'(cmd.row), XW'(cmd.col)};
		cell_ra = nb[CW-1:0];
		par_we  = 1'b0;
		par_wa  = nb_q;
		par_wd  = MV_NONE;
		par_ra  = nb;
		que_we  = 1'b0;
		que_wa  = tail_q[AW-1:0];
		que_wd  = nb_q;
		que_ra  = head_q[AW-1:0];
		unique case (state_q)
			ST_RCLR: begin
				par_we = 1'b1;
				par_wa = clr_q[AW-1:0];
				if (clr_q[AW]) begin
					par_we  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid) begin
					if (cmd.kind == KIND_CELL) begin
						cell_we = cmd.in_grid;
					end else if (cmd.kind == KIND_LAST) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				if (term_q[0].in_grid) begin
					par_we  = 1'b1;
					par_wa  = start_node;
					par_wd  = MV_START;
					que_we  = 1'b1;
					que_wa  = '0;
					que_wd  = start_node;
					state_d = ST_POP;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_POP: begin
				state_d = (head_q == tail_q) ? ST_CHK : ST_POP_W;
			end
			ST_POP_W: begin
				cell_ra = que_rd_q[CW-1:0];
				par_ra  = que_rd_q;
				state_d = ST_CUR_W;
			end
			ST_CUR_W: begin
				state_d = ST_MOVE;
			end
			ST_MOVE: begin
				if (nb_ok) begin
					state_d = ST_NB_W;
				end else if (last_move) begin
					state_d = ST_POP;
				end
			end
			ST_NB_W: begin
				state_d = last_move ? ST_POP : ST_MOVE;
				if (nb_pass) begin
					if (par_rd_q == MV_NONE) begin
						par_we = 1'b1;
						par_wd = move_q;
						que_we = 1'b1;
					end else if (par_cur_q != inverse_move(move_q)) begin
						state_d = ST_CHK;
					end
				end
			end
			ST_CHK: begin
				par_ra = chk_node;
				if (chk_q == tcount_q || !chk_term.in_grid) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_CHK_W;
				end
			end
			ST_CHK_W: begin
				state_d = (par_rd_q == MV_NONE) ? ST_RESULT : ST_CHK;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				// Visited nodes are exactly the queue contents; replay them to clear.
				que_ra = clr_q[AW-1:0];
				par_we = pend_q;
				par_wa = que_rd_q;
				par_wd = MV_NONE;
				if (clr_q == tail_q && !pend_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cmd.code;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (que_we) begin
			que_mem[que_wa] <= que_wd;
		end
		que_rd_q <= que_mem[que_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd.kind != KIND_CELL
				&& tcount_q < TCW'(MAX_TERMINALS)) begin
			term_q[tcount_q[TIW-1:0]] <= '{in_grid: cmd.in_grid, col: cmd.col,
				row: cmd.row, layer: cmd.layer};
		end
		if (state_q == ST_POP_W) begin
			cur_q <= que_rd_q;
		end
		if (state_q == ST_CUR_W) begin
			cell_cur_q <= cell_rd_q;
			par_cur_q  <= move_t'(par_rd_q);
		end
		if (state_q == ST_MOVE) begin
			nb_q <= nb;
		end
		if (state_q == ST_RESULT && out_free) begin
			result_q.net_passed        <= reached_q && !cyc_q && !ovf_q;
			result_q.cycle_seen        <= cyc_q;
			result_q.all_reached       <= reached_q;
			result_q.terminals_dropped <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RCLR;
			clr_q          <= '0;
			pend_q         <= 1'b0;
			head_q         <= '0;
			tail_q         <= '0;
			move_q         <= MV_LEFT;
			tcount_q       <= '0;
			chk_q          <= '0;
			ovf_q          <= 1'b0;
			cyc_q          <= 1'b0;
			reached_q      <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RESULT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RCLR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (cmd_valid && cmd.kind != KIND_CELL) begin
						if (tcount_q < TCW'(MAX_TERMINALS)) begin
							tcount_q <= tcount_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					head_q    <= '0;
					tail_q    <= term_q[0].in_grid ? (AW+1)'(1) : '0;
					chk_q     <= '0;
					cyc_q     <= 1'b0;
					reached_q <= 1'b1;
				end
				ST_POP: begin
					if (head_q != tail_q) begin
						head_q <= head_q + 1'b1;
					end
				end
				ST_CUR_W: begin
					move_q <= MV_LEFT;
				end
				ST_MOVE: begin
					if (!nb_ok && !last_move) begin
						move_q <= move_t'(move_q + 3'd1);
					end
				end
				ST_NB_W: begin
					if (!last_move) begin
						move_q <= move_t'(move_q + 3'd1);
					end
					if (nb_pass) begin
						if (par_rd_q == MV_NONE) begin
							tail_q <= tail_q + 1'b1;
						end else if (par_cur_q != inverse_move(move_q)) begin
							cyc_q <= 1'b1;
						end
					end
				end
				ST_CHK: begin
					if (chk_q != tcount_q && !chk_term.in_grid) begin
						reached_q <= 1'b0;
					end
				end
				ST_CHK_W: begin
					if (par_rd_q == MV_NONE) begin
						reached_q <= 1'b0;
					end else begin
						chk_q <= chk_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						tcount_q       <= '0;
						ovf_q          <= 1'b0;
						clr_q          <= '0;
						pend_q         <= 1'b0;
					end
				end
				ST_CLR: begin
					pend_q <= (clr_q != tail_q);
					if (clr_q != tail_q) begin
						clr_q <= clr_q + 1'b1;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[hw/rtl/grid_net_connectivity_checker_unit.sv]
// Channel   Direction  Handshake                  Payload
// item      in         item_valid/item_stall      in_item_t
// result    out        result_valid/result_stall  out_item_t
//
// Cell writes and non-final terminals are taken while the back end is idle;
// a four-entry queue keeps the input flowing while the back end is busy.
// A final terminal starts a search from the first terminal over neighbors that
// pass the bounds and via checks, then checks each terminal and clears the
// visited nodes. After reset the parent memory is cleared first. Result stall
// holds the back end only while a finished result waits.
module grid_net_connectivity_checker_unit import gncc_pkg::*; #(
	parameter int GRID_WIDTH    = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT   = GRID_HEIGHT_DEF,
	parameter int MAX_TERMINALS = MAX_TERMINALS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	gncc_front #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	gncc_back #(
		.GRID_WIDTH    (GRID_WIDTH),
		.GRID_HEIGHT   (GRID_HEIGHT),
		.MAX_TERMINALS (MAX_TERMINALS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
